/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker module i2cbm_chk.
// Each macro expects a signal named clk, and all but CHK_ALWAYS_NEXT also rst_n, in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset
`define CHK_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/i2cbm_pkg.sv */
// Shared types and constants of the I2C bit-level master.
// No dependencies; used by i2cbm_core and i2c_bit_level_master.
`timescale 1ns / 1ps

package i2cbm_pkg;

  // Command codes carried in the mode field
  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_CHACK = 3'd4,
    CMD_ACK   = 3'd5,
    CMD_NACK  = 3'd6
  } cmd_t;

  // Mode code with no meaning; such a transaction starts nothing
  localparam logic [2:0] MODE_RSVD = 3'd7;

  // Sequencer phase; meaning of the steps depends on the active command
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_A    = 3'd1,
    PH_B    = 3'd2,
    PH_C    = 3'd3,
    PH_D    = 3'd4,
    PH_E    = 3'd5
  } phase_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_UNIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_LIMIT  = 1'b1;

  localparam int UNIT_W = 16;
  localparam int LIMIT_W = 8;
  localparam int WAIT_W = 20;
  localparam int CNT_W = 4;

  localparam logic [UNIT_W-1:0]  UNIT_RST  = 16'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 8'd200;

  // Delay counts in units of the delay register
  localparam logic [CNT_W-1:0] DLY_1  = 4'd1;
  localparam logic [CNT_W-1:0] DLY_2  = 4'd2;
  localparam logic [CNT_W-1:0] DLY_5  = 4'd5;
  localparam logic [CNT_W-1:0] DLY_10 = 4'd10;

  localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  // Line sequencer state
  typedef struct packed {
    cmd_t              cmd;
    phase_t            phase;
    logic [WAIT_W-1:0] wait_cnt;
    logic [CNT_W-1:0]  bit_cnt;
    logic [7:0]        shift;
    logic [7:0]        poll;
    logic [7:0]        tx;
    logic              clk_lvl;
    logic              dat_lvl;
    logic              ack_miss;
  } seq_state_t;

  localparam seq_state_t SEQ_RST = '{
    cmd:      CMD_START,
    phase:    PH_IDLE,
    wait_cnt: '0,
    bit_cnt:  '0,
    shift:    8'hff,
    poll:     '0,
    tx:       '0,
    clk_lvl:  1'b1,
    dat_lvl:  1'b1,
    ack_miss: 1'b0
  };

endpackage

/* hw/rtl/i2cbm_core.sv */
// Next-state logic of the I2C line sequencer for one tick.
// Depends on i2cbm_pkg.
`timescale 1ns / 1ps

module i2cbm_core (
  input  i2cbm_pkg::seq_state_t          st,
  input  logic                           cmd_valid,
  input  logic [2:0]                     mode,
  input  logic [7:0]                     write_byte,
  input  logic                           sda_in,
  input  logic [i2cbm_pkg::UNIT_W-1:0]   unit,
  input  logic [i2cbm_pkg::LIMIT_W-1:0]  limit,
  output i2cbm_pkg::seq_state_t          st_nxt,
  output logic                           done
);

  i2cbm_pkg::seq_state_t      s;
  logic                       run;
  logic                       arm;
  logic [i2cbm_pkg::CNT_W-1:0] arm_cnt;
  i2cbm_pkg::phase_t          arm_ph;
  logic                       fin;
  logic [i2cbm_pkg::CNT_W-1:0] bit_inc;
  logic [i2cbm_pkg::CNT_W-1:0] hs_cnt;

  always_comb begin
    s    = st;
    run  = 1'b0;
    // Idle: latch a new command and run its first action this tick
    if (st.phase == i2cbm_pkg::PH_IDLE) begin
      if (cmd_valid && (mode != i2cbm_pkg::MODE_RSVD)) begin
        s.cmd      = i2cbm_pkg::cmd_t'(mode);
        s.phase    = i2cbm_pkg::PH_A;
        s.bit_cnt  = '0;
        s.wait_cnt = '0;
        if (mode == i2cbm_pkg::CMD_WRITE) begin
          s.tx = write_byte;
        end
        if (mode == i2cbm_pkg::CMD_READ) begin
          s.shift = 8'hff;
        end
        run = 1'b1;
      end
    end else if (st.wait_cnt != '0) begin
      s.wait_cnt = st.wait_cnt - 1'b1;
    end else begin
      run = 1'b1;
    end
  end

  // Action table: one line action per command and phase
  always_comb begin
    st_nxt  = s;
    arm     = 1'b0;
    arm_cnt = i2cbm_pkg::DLY_1;
    arm_ph  = i2cbm_pkg::PH_IDLE;
    fin     = 1'b0;
    bit_inc = s.bit_cnt + 1'b1;
    hs_cnt  = (s.cmd == i2cbm_pkg::CMD_ACK) ? i2cbm_pkg::DLY_1 : i2cbm_pkg::DLY_2;
    if (run) begin
      case (s.cmd)
        i2cbm_pkg::CMD_START: begin
          case (s.phase)
            i2cbm_pkg::PH_A: begin
              arm = 1'b1; arm_cnt = i2cbm_pkg::DLY_5; arm_ph = i2cbm_pkg::PH_B;
            end
            i2cbm_pkg::PH_B: begin
              st_nxt.dat_lvl = 1'b1;
              st_nxt.clk_lvl = 1'b1;
              arm = 1'b1; arm_cnt = i2cbm_pkg::DLY_10; arm_ph = i2cbm_pkg::PH_C;
            end
            i2cbm_pkg::PH_C: begin
              st_nxt.dat_lvl = 1'b0;
              arm = 1'b1; arm_cnt = i2cbm_pkg::DLY_10; arm_ph = i2cbm_pkg::PH_D;
            end
            i2cbm_pkg::PH_D: begin
              st_nxt.clk_lvl = 1'b0;
              arm = 1'b1; arm_cnt = i2cbm_pkg::DLY_10; arm_ph = i2cbm_pkg::PH_E;
            end
            default: fin = 1'b1;
          endcase
        end
        i2cbm_pkg::CMD_STOP: begin
          case (s.phase)
            i2cbm_pkg::PH_A: begin
              st_nxt.dat_lvl = 1'b0;
              st_nxt.clk_lvl = 1'b1;
              arm = 1'b1; arm_cnt = i2cbm_pkg::DLY_5; arm_ph = i2cbm_pkg::PH_B;
            end
            i2cbm_pkg::PH_B: begin
              st_nxt.dat_lvl = 1'b1;
              arm = 1'b1; arm_cnt = i2cbm_pkg::DLY_5; arm_ph = i2cbm_pkg::PH_C;
            end
            default: fin = 1'b1;
          endcase
        end
        i2cbm_pkg::CMD_WRITE: begin
          case (s.phase)
            i2cbm_pkg::PH_A: begin
              st_nxt.dat_lvl = s.tx[7];
              arm = 1'b1; arm_cnt = i2cbm_pkg::DLY_2; arm_ph = i2cbm_pkg::PH_B;
            end
            i2cbm_pkg::PH_B: begin
              st_nxt.clk_lvl = 1'b1;
              arm = 1'b1; arm_cnt = i2cbm_pkg::DLY_2; arm_ph = i2cbm_pkg::PH_C;
            end
            i2cbm_pkg::PH_C: begin
              st_nxt.clk_lvl = 1'b0;
              st_nxt.tx      = {s.tx[6:0], 1'b0};
              st_nxt.bit_cnt = bit_inc;
              arm = 1'b1; arm_cnt = i2cbm_pkg::DLY_2;
              arm_ph = (bit_inc < i2cbm_pkg::BITS_PER_BYTE) ? i2cbm_pkg::PH_A
                                                            : i2cbm_pkg::PH_D;
            end
            default: begin
              st_nxt.dat_lvl = 1'b1;
              fin = 1'b1;
            end
          endcase
        end
        i2cbm_pkg::CMD_READ: begin
          case (s.phase)
            i2cbm_pkg::PH_A: begin
              st_nxt.dat_lvl = 1'b1;
              st_nxt.clk_lvl = 1'b1;
              arm = 1'b1; arm_cnt = i2cbm_pkg::DLY_2; arm_ph = i2cbm_pkg::PH_B;
            end
            i2cbm_pkg::PH_B: begin
              // sample SDA while SCL is still high
              st_nxt.shift   = {s.shift[6:0], sda_in};
              st_nxt.clk_lvl = 1'b0;
              st_nxt.bit_cnt = bit_inc;
              arm = 1'b1; arm_cnt = i2cbm_pkg::DLY_2;
              arm_ph = (bit_inc < i2cbm_pkg::BITS_PER_BYTE) ? i2cbm_pkg::PH_A
                                                            : i2cbm_pkg::PH_C;
            end
            default: fin = 1'b1;
          endcase
        end
        i2cbm_pkg::CMD_CHACK: begin
          case (s.phase)
            i2cbm_pkg::PH_A: begin
              st_nxt.dat_lvl = 1'b1;
              arm = 1'b1; arm_cnt = i2cbm_pkg::DLY_2; arm_ph = i2cbm_pkg::PH_B;
            end
            i2cbm_pkg::PH_B: begin
              st_nxt.clk_lvl = 1'b1;
              st_nxt.poll    = limit;
              arm = 1'b1; arm_cnt = i2cbm_pkg::DLY_2; arm_ph = i2cbm_pkg::PH_C;
            end
            default: begin
              // poll: low SDA is an ack, last high poll is a timeout
              if (!sda_in) begin
                st_nxt.clk_lvl  = 1'b0;
                st_nxt.ack_miss = 1'b0;
                fin = 1'b1;
              end else if (s.poll <= 8'd1) begin
                st_nxt.clk_lvl  = 1'b0;
                st_nxt.ack_miss = 1'b1;
                fin = 1'b1;
              end else begin
                st_nxt.poll = s.poll - 1'b1;
                arm = 1'b1; arm_cnt = i2cbm_pkg::DLY_2; arm_ph = i2cbm_pkg::PH_C;
              end
            end
          endcase
        end
        default: begin
          // send ack / send nack
          case (s.phase)
            i2cbm_pkg::PH_A: begin
              st_nxt.dat_lvl = (s.cmd != i2cbm_pkg::CMD_ACK);
              arm = 1'b1; arm_cnt = hs_cnt; arm_ph = i2cbm_pkg::PH_B;
            end
            i2cbm_pkg::PH_B: begin
              st_nxt.clk_lvl = 1'b1;
              arm = 1'b1; arm_cnt = hs_cnt; arm_ph = i2cbm_pkg::PH_C;
            end
            i2cbm_pkg::PH_C: begin
              st_nxt.clk_lvl = 1'b0;
              arm = 1'b1; arm_cnt = hs_cnt; arm_ph = i2cbm_pkg::PH_D;
            end
            default: begin
              st_nxt.dat_lvl = 1'b1;
              fin = 1'b1;
            end
          endcase
        end
      endcase
    end

    // Load the wait counter: count times the delay unit fits in 20 bits
    if (arm) begin
      st_nxt.wait_cnt = {{(i2cbm_pkg::WAIT_W-i2cbm_pkg::UNIT_W){1'b0}}, unit}
                      * {{(i2cbm_pkg::WAIT_W-i2cbm_pkg::CNT_W){1'b0}}, arm_cnt};
      st_nxt.phase    = arm_ph;
    end
    if (fin) begin
      st_nxt.phase    = i2cbm_pkg::PH_IDLE;
      st_nxt.wait_cnt = '0;
    end
    done = fin;
  end

endmodule

/* hw/rtl/i2c_bit_level_master.sv */
// Top level of the tick-driven I2C bit-level master.
// Depends on i2cbm_pkg and i2cbm_core.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_ready  cmd_valid, mode, write_byte, sda_in
//   out_     output     out_valid/out_ready  scl_out, sda_out, busy_res, done_res,
//                                            read_byte, no_ack
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// One transaction per cycle while in_ready is high: each accepted transaction is one
// sequencer tick, and its result is in the output register on the next cycle.
// The sequencer state and the output register advance only on an accepted tick.
// in_ready is high while the output register is empty or being drained.
// Synchronous active-low reset; no clearing pass.
`timescale 1ns / 1ps

module i2c_bit_level_master (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cmd_valid,
  input  logic [2:0]                        in_mode,
  input  logic [7:0]                        in_write_byte,
  input  logic                              in_sda_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_scl_out,
  output logic                              out_sda_out,
  output logic                              out_busy_res,
  output logic                              out_done_res,
  output logic [7:0]                        out_read_byte,
  output logic                              out_no_ack,
  input  logic                              cfg_we,
  input  logic [i2cbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2cbm_pkg::UNIT_W-1:0]      cfg_wdata
);

  logic [i2cbm_pkg::UNIT_W-1:0]  unit_r;
  logic [i2cbm_pkg::LIMIT_W-1:0] limit_r;
  i2cbm_pkg::seq_state_t         st_r;
  i2cbm_pkg::seq_state_t         st_nxt;
  logic                          done_nxt;
  logic                          accept;
  logic                          out_valid_r;
  logic                          busy_nxt;
  logic                          scl_r, sda_r, busy_r, done_r, nack_r;
  logic [7:0]                    rbyte_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r  <= i2cbm_pkg::UNIT_RST;
      limit_r <= i2cbm_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cbm_pkg::REG_DELAY_UNIT: unit_r  <= cfg_wdata;
        i2cbm_pkg::REG_ACK_LIMIT:  limit_r <= cfg_wdata[i2cbm_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  i2cbm_core u_core (
    .st         (st_r),
    .cmd_valid  (in_cmd_valid),
    .mode       (in_mode),
    .write_byte (in_write_byte),
    .sda_in     (in_sda_in),
    .unit       (unit_r),
    .limit      (limit_r),
    .st_nxt     (st_nxt),
    .done       (done_nxt)
  );

  // Status decode for the result
  always_comb begin
    busy_nxt = (st_nxt.phase != i2cbm_pkg::PH_IDLE);
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= i2cbm_pkg::SEQ_RST;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scl_r   <= st_nxt.clk_lvl;
      sda_r   <= st_nxt.dat_lvl;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      rbyte_r <= st_nxt.shift;
      nack_r  <= st_nxt.ack_miss;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_out   = scl_r;
  assign out_sda_out   = sda_r;
  assign out_busy_res  = busy_r;
  assign out_done_res  = done_r;
  assign out_read_byte = rbyte_r;
  assign out_no_ack    = nack_r;

endmodule

/* hw/rtl/i2cbm_chk.sv */
// Port-level checker for i2c_bit_level_master, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cbm_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_scl_out,
  input logic                              out_sda_out,
  input logic                              out_busy_res,
  input logic                              out_done_res,
  input logic [7:0]                        out_read_byte,
  input logic                              out_no_ack
);

  // A finishing tick leaves the sequencer idle
  `CHK_IMPLY(a_done_idle, out_valid && out_done_res, !out_busy_res, "done while busy")

  // Every accepted tick produces a result on the next cycle
  `CHK_NEXT(a_tick_result, in_valid && in_ready, out_valid, "accepted tick lost")

  // An empty output register never stalls the input
  `CHK_IMPLY(a_ready_empty, !out_valid, in_ready, "input stalled with empty output")

  // A stalled result holds
  `CHK_NEXT(a_out_hold, out_valid && !out_ready,
            out_valid && $stable(out_scl_out) && $stable(out_sda_out)
            && $stable(out_busy_res) && $stable(out_done_res)
            && $stable(out_read_byte) && $stable(out_no_ack), "stalled result changed")

  // No result right after reset
  `CHK_ALWAYS_NEXT(a_rst_empty, !rst_n, !out_valid, "result valid after reset")

endmodule

bind i2c_bit_level_master i2cbm_chk u_i2cbm_chk (.*);

/* tb/sv/i2c_bit_level_master_tb.sv */
// Self-checking testbench for the tick-driven I2C bit-level master.
// Depends on i2cbm_pkg and the i2c_bit_level_master RTL; it has a line-level predictor,
// a queued valid/ready driver, a result monitor and a no-progress watchdog.
`timescale 1ns / 1ps

module i2c_bit_level_master_tb;
  import i2cbm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_CMDS = 120;
  localparam int TICK_BUDGET = 800;

  // Work list entries: a tick to send, or a control marker for the driver
  typedef enum logic [1:0] {PLAN_TICK, PLAN_SETTLE, PLAN_DRAIN, PLAN_REG} plan_kind_e;

  typedef struct {
    plan_kind_e           kind;
    logic                 cmd_valid;
    logic [2:0]           mode;
    logic [7:0]           wbyte;
    logic                 sda;
    int                   sda_pct;
    int                   noise_pct;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [UNIT_W-1:0]    reg_data;
  } plan_entry_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rbyte;
    logic       nack;
  } bus_levels_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd_valid = 1'b0;
  logic [2:0] in_mode = '0;
  logic [7:0] in_write_byte = '0;
  logic in_sda_in = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_scl_out;
  logic out_sda_out;
  logic out_busy_res;
  logic out_done_res;
  logic [7:0] out_read_byte;
  logic out_no_ack;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [UNIT_W-1:0] cfg_wdata = '0;

  i2c_bit_level_master dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd_valid  (in_cmd_valid),
    .in_mode       (in_mode),
    .in_write_byte (in_write_byte),
    .in_sda_in     (in_sda_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_scl_out   (out_scl_out),
    .out_sda_out   (out_sda_out),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_read_byte (out_read_byte),
    .out_no_ack    (out_no_ack),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  plan_entry_t line_plan[$];
  bus_levels_t bus_levels_due[$];
  int sda_mix [4] = '{0, 30, 70, 100};

  // Predictor copy of the configuration and sequencer state
  logic [UNIT_W-1:0]  cf_unit  = UNIT_RST;
  logic [LIMIT_W-1:0] cf_limit = LIMIT_RST;
  cmd_t              seq_cmd   = CMD_START;
  phase_t            seq_phase = PH_IDLE;
  logic [WAIT_W-1:0] seq_wait  = '0;
  logic [CNT_W-1:0]  seq_bits  = '0;
  logic [7:0]        seq_shift = 8'hff;
  logic [7:0]        seq_polls = '0;
  logic [7:0]        seq_tx    = '0;
  logic              seq_scl   = 1'b1;
  logic              seq_sda   = 1'b1;
  logic              seq_nack  = 1'b0;
  logic              seq_done  = 1'b0;

  // Bookkeeping
  logic in_acc = 1'b0;
  int   gap_left = 0;
  int   burst_left = 1;
  int   idle_cycles = 0;
  int   cmd_items = 0;
  int   n_sent = 0;
  int   n_faults = 0;
  int   n_results = 0;
  int   n_ignored = 0;
  int   n_timeouts = 0;
  int   n_reg_writes = 0;
  int   n_drains = 0;
  int   n_by_cmd [7] = '{default: 0};

  // ---------------------------------------------------------------- predictor

  task automatic arm_wait(input logic [CNT_W-1:0] count, input phase_t nxt);
    logic [31:0] prod;
    prod = 32'(count) * 32'(cf_unit);
    seq_wait = prod[WAIT_W-1:0];
    seq_phase = nxt;
  endtask

  task automatic end_sequence();
    seq_phase = PH_IDLE;
    seq_wait = '0;
    seq_done = 1'b1;
  endtask

  // One line action of the active command, at the current phase
  task automatic run_line_action(input logic sda);
    logic [CNT_W-1:0] hs;
    case (seq_cmd)
      CMD_START: begin
        if (seq_phase == PH_A) arm_wait(DLY_5, PH_B);
        else if (seq_phase == PH_B) begin
          seq_sda = 1'b1; seq_scl = 1'b1; arm_wait(DLY_10, PH_C);
        end else if (seq_phase == PH_C) begin
          seq_sda = 1'b0; arm_wait(DLY_10, PH_D);
        end else if (seq_phase == PH_D) begin
          seq_scl = 1'b0; arm_wait(DLY_10, PH_E);
        end else end_sequence();
      end
      CMD_STOP: begin
        if (seq_phase == PH_A) begin
          seq_sda = 1'b0; seq_scl = 1'b1; arm_wait(DLY_5, PH_B);
        end else if (seq_phase == PH_B) begin
          seq_sda = 1'b1; arm_wait(DLY_5, PH_C);
        end else end_sequence();
      end
      CMD_WRITE: begin
        if (seq_phase == PH_A) begin
          seq_sda = seq_tx[7]; arm_wait(DLY_2, PH_B);
        end else if (seq_phase == PH_B) begin
          seq_scl = 1'b1; arm_wait(DLY_2, PH_C);
        end else if (seq_phase == PH_C) begin
          seq_scl = 1'b0;
          seq_tx = {seq_tx[6:0], 1'b0};
          seq_bits = seq_bits + 1'b1;
          if (seq_bits < BITS_PER_BYTE) arm_wait(DLY_2, PH_A);
          else arm_wait(DLY_2, PH_D);
        end else begin
          seq_sda = 1'b1; end_sequence();
        end
      end
      CMD_READ: begin
        if (seq_phase == PH_A) begin
          seq_sda = 1'b1; seq_scl = 1'b1; arm_wait(DLY_2, PH_B);
        end else if (seq_phase == PH_B) begin
          seq_shift = {seq_shift[6:0], sda};
          seq_scl = 1'b0;
          seq_bits = seq_bits + 1'b1;
          if (seq_bits < BITS_PER_BYTE) arm_wait(DLY_2, PH_A);
          else arm_wait(DLY_2, PH_C);
        end else end_sequence();
      end
      CMD_CHACK: begin
        if (seq_phase == PH_A) begin
          seq_sda = 1'b1; arm_wait(DLY_2, PH_B);
        end else if (seq_phase == PH_B) begin
          seq_scl = 1'b1; seq_polls = cf_limit; arm_wait(DLY_2, PH_C);
        end else if (!sda) begin
          seq_scl = 1'b0; seq_nack = 1'b0; end_sequence();
        end else if (seq_polls <= 8'd1) begin
          // poll budget spent (a zero limit counts as one poll)
          seq_scl = 1'b0; seq_nack = 1'b1; n_timeouts++; end_sequence();
        end else begin
          seq_polls = seq_polls - 1'b1; arm_wait(DLY_2, PH_C);
        end
      end
      default: begin
        // send ack / send nack share one shape; nack is slower and leaves SDA released
        hs = (seq_cmd == CMD_ACK) ? DLY_1 : DLY_2;
        if (seq_phase == PH_A) begin
          seq_sda = (seq_cmd == CMD_ACK) ? 1'b0 : 1'b1; arm_wait(hs, PH_B);
        end else if (seq_phase == PH_B) begin
          seq_scl = 1'b1; arm_wait(hs, PH_C);
        end else if (seq_phase == PH_C) begin
          seq_scl = 1'b0; arm_wait(hs, PH_D);
        end else begin
          seq_sda = 1'b1; end_sequence();
        end
      end
    endcase
  endtask

  // One tick of the sequencer; returns the levels seen after it
  task automatic advance_bus_sequencer(input logic cv, input logic [2:0] m,
                                       input logic [7:0] wb, input logic sda,
                                       output bus_levels_t lv);
    seq_done = 1'b0;
    if (seq_phase == PH_IDLE) begin
      if (cv && m != MODE_RSVD) begin
        seq_cmd = cmd_t'(m);
        seq_phase = PH_A;
        seq_bits = '0;
        seq_wait = '0;
        if (m == CMD_WRITE) seq_tx = wb;
        if (m == CMD_READ) seq_shift = 8'hff;
        n_by_cmd[m]++;
        run_line_action(sda);
      end else if (cv) n_ignored++;
    end else begin
      if (cv) n_ignored++;
      if (seq_wait != '0) seq_wait = seq_wait - 1'b1;
      else run_line_action(sda);
    end
    lv.scl = seq_scl;
    lv.sda = seq_sda;
    lv.busy = (seq_phase != PH_IDLE);
    lv.done = seq_done;
    lv.rbyte = seq_shift;
    lv.nack = seq_nack;
  endtask

  // ---------------------------------------------------------------- work list

  task automatic queue_tick(input logic cv, input logic [2:0] m, input logic [7:0] wb,
                            input logic sda);
    plan_entry_t e;
    e.kind = PLAN_TICK;
    e.cmd_valid = cv;
    e.mode = m;
    e.wbyte = wb;
    e.sda = sda;
    e.sda_pct = 0;
    e.noise_pct = 0;
    line_plan.push_back(e);
  endtask

  task automatic queue_marker(input plan_kind_e k, input int sda_pct, input int noise_pct);
    plan_entry_t e;
    e.kind = k;
    e.cmd_valid = 1'b0;
    e.sda_pct = sda_pct;
    e.noise_pct = noise_pct;
    line_plan.push_back(e);
  endtask

  // A command, then filler ticks until the sequence ends
  task automatic queue_cmd(input logic [2:0] m, input logic [7:0] wb, input int sda_pct,
                           input int noise_pct);
    queue_tick(1'b1, m, wb, $urandom_range(0, 99) < sda_pct);
    queue_marker(PLAN_SETTLE, sda_pct, noise_pct);
    if (m != MODE_RSVD) cmd_items++;
  endtask

  // Register write, once the sequencer has gone idle and all results are out
  task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [UNIT_W-1:0] data);
    plan_entry_t e;
    queue_marker(PLAN_SETTLE, 50, 0);
    e.kind = PLAN_REG;
    e.reg_idx = idx;
    e.reg_data = data;
    line_plan.push_back(e);
  endtask

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin : drive
    plan_entry_t e;
    logic v_nxt, we_nxt, load, cv_nxt, sda_nxt;
    logic [2:0] mode_nxt;
    logic [7:0] byte_nxt;
    logic [CFG_IDX_W-1:0] idx_nxt;
    logic [UNIT_W-1:0] data_nxt;
    if (rst_n) begin
      v_nxt = in_valid && !in_acc;
      we_nxt = 1'b0;
      load = 1'b0;
      cv_nxt = 1'b0;
      sda_nxt = 1'b0;
      mode_nxt = '0;
      byte_nxt = '0;
      idx_nxt = '0;
      data_nxt = '0;
      if (!v_nxt && gap_left > 0) gap_left--;
      else if (!v_nxt && line_plan.size() > 0) begin
        e = line_plan[0];
        case (e.kind)
          PLAN_TICK: begin
            if (n_sent >= TICK_BUDGET) begin
              // tick budget spent: drop the rest of the plan at a command boundary
              line_plan.delete();
            end else begin
              line_plan.delete(0);
              load = 1'b1;
              cv_nxt = e.cmd_valid;
              mode_nxt = e.mode;
              byte_nxt = e.wbyte;
              sda_nxt = e.sda;
            end
          end
          PLAN_SETTLE: begin
            if (seq_phase != PH_IDLE) begin
              // filler tick; sometimes a stray command that must be ignored
              load = 1'b1;
              cv_nxt = $urandom_range(0, 99) < e.noise_pct;
              mode_nxt = 3'($urandom_range(0, 7));
              byte_nxt = 8'($urandom);
              sda_nxt = $urandom_range(0, 99) < e.sda_pct;
            end else line_plan.delete(0);
          end
          PLAN_DRAIN: begin
            if (bus_levels_due.size() == 0) begin
              line_plan.delete(0);
              n_drains++;
            end
          end
          default: begin
            if (bus_levels_due.size() == 0) begin
              line_plan.delete(0);
              we_nxt = 1'b1;
              idx_nxt = e.reg_idx;
              data_nxt = e.reg_data;
              if (e.reg_idx == REG_DELAY_UNIT) cf_unit = e.reg_data;
              else cf_limit = e.reg_data[LIMIT_W-1:0];
              n_reg_writes++;
            end
          end
        endcase
        if (load) begin
          v_nxt = 1'b1;
          n_sent++;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600)
                                                     : $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_valid <= v_nxt;
      if (load) begin
        in_cmd_valid <= cv_nxt;
        in_mode <= mode_nxt;
        in_write_byte <= byte_nxt;
        in_sda_in <= sda_nxt;
      end
      cfg_we <= we_nxt;
      cfg_index <= idx_nxt;
      cfg_wdata <= data_nxt;
    end
  end

  // Receiver back-pressure: the mode switches when its random run length is used up
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  always @(negedge clk) begin : backpressure
    logic rdy;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(32, 256);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0: rdy = 1'b1;
      1: rdy = (stall_tick % 4) != 3;
      2: rdy = 1'($urandom_range(0, 1));
      default: rdy = (stall_tick % 16) < 10;
    endcase
    out_ready <= rdy;
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : observe
    bus_levels_t got, want;
    if (!rst_n) in_acc = 1'b0;
    else begin
      // check the result transaction against the oldest prediction
      if (out_valid && out_ready) begin
        got.scl = out_scl_out;
        got.sda = out_sda_out;
        got.busy = out_busy_res;
        got.done = out_done_res;
        got.rbyte = out_read_byte;
        got.nack = out_no_ack;
        n_results++;
        if (bus_levels_due.size() == 0) begin
          n_faults++;
          if (n_faults <= 10)
            $display("ERROR %0t: unexpected result scl=%b sda=%b busy=%b done=%b rd=%h nack=%b",
                     $realtime, got.scl, got.sda, got.busy, got.done, got.rbyte, got.nack);
        end else begin
          want = bus_levels_due.pop_front();
          if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy ||
              got.done !== want.done || got.rbyte !== want.rbyte || got.nack !== want.nack) begin
            n_faults++;
            if (n_faults <= 10)
              $display({"ERROR %0t: result %0d expected scl=%b sda=%b busy=%b done=%b rd=%h ",
                        "nack=%b, got scl=%b sda=%b busy=%b done=%b rd=%h nack=%b"},
                       $realtime, n_results, want.scl, want.sda, want.busy, want.done,
                       want.rbyte, want.nack, got.scl, got.sda, got.busy, got.done,
                       got.rbyte, got.nack);
          end
        end
      end
      // predict the accepted tick
      in_acc = in_valid && in_ready;
      if (in_acc) begin
        advance_bus_sequencer(in_cmd_valid, in_mode, in_write_byte, in_sda_in, want);
        bus_levels_due.push_back(want);
      end
    end
  end

  // Watchdog on transactions in either direction
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    int rnd_start;
    int next_reg;
    int noise;
    int k;
    logic [UNIT_W-1:0] unit;
    logic [LIMIT_W-1:0] lim;

    // Directed: every command at reset settings
    queue_tick(1'b1, MODE_RSVD, 8'h3c, 1'b0);
    queue_cmd(CMD_START, 8'h00, 50, 20);
    queue_cmd(CMD_WRITE, 8'hff, 50, 20);
    queue_cmd(CMD_CHACK, 8'h00, 0, 20);
    queue_cmd(CMD_READ, 8'h00, 100, 20);
    queue_cmd(CMD_ACK, 8'h00, 50, 20);
    queue_cmd(CMD_READ, 8'hff, 0, 20);
    queue_cmd(CMD_NACK, 8'h00, 50, 20);
    queue_cmd(CMD_STOP, 8'h00, 50, 20);
    // zero delay unit and zero poll limit
    queue_reg(REG_DELAY_UNIT, 16'h0000);
    queue_reg(REG_ACK_LIMIT, {8'($urandom), 8'h00});
    queue_cmd(CMD_START, 8'h00, 50, 20);
    queue_cmd(CMD_WRITE, 8'ha5, 50, 20);
    queue_cmd(CMD_CHACK, 8'h00, 100, 20);
    queue_cmd(CMD_READ, 8'h00, 50, 20);
    queue_cmd(CMD_ACK, 8'h00, 50, 20);
    queue_cmd(CMD_NACK, 8'h00, 50, 20);
    queue_cmd(CMD_STOP, 8'h00, 50, 20);
    // single poll at a two-tick unit
    queue_reg(REG_DELAY_UNIT, 16'd2);
    queue_reg(REG_ACK_LIMIT, {8'($urandom), 8'h01});
    queue_cmd(CMD_CHACK, 8'h00, 100, 20);
    queue_cmd(CMD_CHACK, 8'h00, 30, 20);
    // widest poll budget, polled back to back with a zero delay unit
    queue_reg(REG_DELAY_UNIT, 16'd0);
    queue_reg(REG_ACK_LIMIT, {8'($urandom), 8'hff});
    queue_cmd(CMD_CHACK, 8'h00, 100, 20);
    queue_marker(PLAN_DRAIN, 0, 0);
    // a longer delay unit, on the shortest command
    queue_reg(REG_DELAY_UNIT, 16'h0010);
    queue_cmd(CMD_ACK, 8'h00, 50, 5);

    // Random: mostly well-formed transfers, with stray and undefined commands mixed in
    rnd_start = cmd_items;
    next_reg = cmd_items;
    while (cmd_items - rnd_start < RANDOM_CMDS) begin
      if (cmd_items >= next_reg) begin
        k = $urandom_range(0, 9);
        unit = (k < 2) ? 16'd0 : (k < 6) ? 16'd1 : (k < 8) ? 16'd2 : 16'd3;
        k = $urandom_range(0, 5);
        lim = (k == 0) ? 8'd0 : (k == 1) ? 8'd1 : (k == 2) ? 8'd2 : (k == 3) ? 8'd3 :
              (k == 4) ? 8'd8 : 8'($urandom_range(4, 16));
        queue_reg(REG_DELAY_UNIT, unit);
        queue_reg(REG_ACK_LIMIT, {8'($urandom), lim});
        next_reg = cmd_items + $urandom_range(4, 10);
      end
      noise = $urandom_range(0, 30);
      if ($urandom_range(0, 9) < 7) begin
        queue_cmd(CMD_START, 8'($urandom), 50, noise);
        queue_cmd(CMD_WRITE, 8'($urandom), 50, noise);
        queue_cmd(CMD_CHACK, 8'($urandom), sda_mix[$urandom_range(0, 3)], noise);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1)) begin
            queue_cmd(CMD_WRITE, 8'($urandom), 50, noise);
            queue_cmd(CMD_CHACK, 8'($urandom), sda_mix[$urandom_range(0, 3)], noise);
          end else begin
            queue_cmd(CMD_READ, 8'($urandom), $urandom_range(0, 100), noise);
            if ($urandom_range(0, 1)) queue_cmd(CMD_ACK, 8'($urandom), 50, noise);
            else queue_cmd(CMD_NACK, 8'($urandom), 50, noise);
          end
        end
        queue_cmd(CMD_STOP, 8'($urandom), 50, noise);
      end else begin
        repeat ($urandom_range(1, 4))
          queue_cmd(3'($urandom_range(0, 7)), 8'($urandom), sda_mix[$urandom_range(0, 3)],
                    noise);
      end
      if ($urandom_range(0, 7) == 0) queue_marker(PLAN_DRAIN, 0, 0);
    end

    // Reset, then let the driver work through the list
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (line_plan.size() != 0 || in_valid || bus_levels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("summary: %0d ticks checked; started start=%0d stop=%0d write=%0d read=%0d",
             n_results, n_by_cmd[CMD_START], n_by_cmd[CMD_STOP], n_by_cmd[CMD_WRITE],
             n_by_cmd[CMD_READ]);
    $display("summary: chack=%0d (%0d timed out) ack=%0d nack=%0d ignored=%0d regs=%0d drains=%0d",
             n_by_cmd[CMD_CHACK], n_timeouts, n_by_cmd[CMD_ACK], n_by_cmd[CMD_NACK],
             n_ignored, n_reg_writes, n_drains);
    if (n_faults == 0) begin
      $display("tb: success");
    end else begin
      $display("ERROR: %0d mismatches", n_faults);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
